// ===== rtl/kbfifo_pkg.sv =====
package kbfifo_pkg;

    // Default character queue depth (holds one entry fewer)
    localparam int unsigned FIFO_DEPTH_DEF = 128;

    // Command codes
    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    // Set-1 scancodes of interest
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CTRL_MAKE    = 8'h1D;
    localparam logic [7:0] SC_CTRL_BREAK   = 8'h9D;
    localparam logic [7:0] SC_ALT_MAKE     = 8'h38;
    localparam logic [7:0] SC_ALT_BREAK    = 8'hB8;
    localparam logic [7:0] SC_CAPS_MAKE    = 8'h3A;
    localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;
    localparam logic [7:0] SC_CAPS_LO      = 8'h10;
    localparam logic [7:0] SC_CAPS_HI      = 8'h32;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;

    // Modifier bit positions
    localparam int unsigned MOD_SHIFT = 0;
    localparam int unsigned MOD_CTRL  = 1;
    localparam int unsigned MOD_ALT   = 2;
    localparam int unsigned MOD_CAPS  = 3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] scancode;
    } kbfifo_in_t;

    typedef struct packed {
        logic [7:0] read_char;
        logic       read_valid;
        logic       available;
        logic [3:0] modifier_state;
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       queue_dropped;
    } kbfifo_out_t;

    function automatic logic [7:0] lower_map(input logic [6:0] code);
        logic [7:0] c;
        case (code)
            7'd1:  c = 8'h1B;
            7'd2:  c = 8'h31;
            7'd3:  c = 8'h32;
            7'd4:  c = 8'h33;
            7'd5:  c = 8'h34;
            7'd6:  c = 8'h35;
            7'd7:  c = 8'h36;
            7'd8:  c = 8'h37;
            7'd9:  c = 8'h38;
            7'd10: c = 8'h39;
            7'd11: c = 8'h30;
            7'd12: c = 8'h2D;
            7'd13: c = 8'h3D;
            7'd14: c = 8'h08;
            7'd15: c = 8'h09;
            7'd16: c = 8'h71;
            7'd17: c = 8'h77;
            7'd18: c = 8'h65;
            7'd19: c = 8'h72;
            7'd20: c = 8'h74;
            7'd21: c = 8'h79;
            7'd22: c = 8'h75;
            7'd23: c = 8'h69;
            7'd24: c = 8'h6F;
            7'd25: c = 8'h70;
            7'd26: c = 8'h5B;
            7'd27: c = 8'h5D;
            7'd28: c = 8'h0A;
            7'd30: c = 8'h61;
            7'd31: c = 8'h73;
            7'd32: c = 8'h64;
            7'd33: c = 8'h66;
            7'd34: c = 8'h67;
            7'd35: c = 8'h68;
            7'd36: c = 8'h6A;
            7'd37: c = 8'h6B;
            7'd38: c = 8'h6C;
            7'd39: c = 8'h3B;
            7'd40: c = 8'h27;
            7'd41: c = 8'h60;
            7'd43: c = 8'h5C;
            7'd44: c = 8'h7A;
            7'd45: c = 8'h78;
            7'd46: c = 8'h63;
            7'd47: c = 8'h76;
            7'd48: c = 8'h62;
            7'd49: c = 8'h6E;
            7'd50: c = 8'h6D;
            7'd51: c = 8'h2C;
            7'd52: c = 8'h2E;
            7'd53: c = 8'h2F;
            7'd55: c = 8'h2A;
            7'd57: c = 8'h20;
            7'd74: c = 8'h2D;
            7'd78: c = 8'h2B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] upper_map(input logic [6:0] code);
        logic [7:0] c;
        case (code)
            7'd1:  c = 8'h1B;
            7'd2:  c = 8'h21;
            7'd3:  c = 8'h40;
            7'd4:  c = 8'h23;
            7'd5:  c = 8'h24;
            7'd6:  c = 8'h25;
            7'd7:  c = 8'h5E;
            7'd8:  c = 8'h26;
            7'd9:  c = 8'h2A;
            7'd10: c = 8'h28;
            7'd11: c = 8'h29;
            7'd12: c = 8'h5F;
            7'd13: c = 8'h2B;
            7'd14: c = 8'h08;
            7'd15: c = 8'h09;
            7'd16: c = 8'h51;
            7'd17: c = 8'h57;
            7'd18: c = 8'h45;
            7'd19: c = 8'h52;
            7'd20: c = 8'h54;
            7'd21: c = 8'h59;
            7'd22: c = 8'h55;
            7'd23: c = 8'h49;
            7'd24: c = 8'h4F;
            7'd25: c = 8'h50;
            7'd26: c = 8'h7B;
            7'd27: c = 8'h7D;
            7'd28: c = 8'h0A;
            7'd30: c = 8'h41;
            7'd31: c = 8'h53;
            7'd32: c = 8'h44;
            7'd33: c = 8'h46;
            7'd34: c = 8'h47;
            7'd35: c = 8'h48;
            7'd36: c = 8'h4A;
            7'd37: c = 8'h4B;
            7'd38: c = 8'h4C;
            7'd39: c = 8'h3A;
            7'd40: c = 8'h22;
            7'd41: c = 8'h7E;
            7'd43: c = 8'h7C;
            7'd44: c = 8'h5A;
            7'd45: c = 8'h58;
            7'd46: c = 8'h43;
            7'd47: c = 8'h56;
            7'd48: c = 8'h42;
            7'd49: c = 8'h4E;
            7'd50: c = 8'h4D;
            7'd51: c = 8'h3C;
            7'd52: c = 8'h3E;
            7'd53: c = 8'h3F;
            7'd55: c = 8'h2A;
            7'd57: c = 8'h20;
            7'd74: c = 8'h2D;
            7'd78: c = 8'h2B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/kbfifo_ram.sv =====
module kbfifo_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/scancode_to_ascii_keyboard_fifo.sv =====
// Set-1 keyboard scancode translator with a character queue. Each command
// transaction on cmd gives exactly one response transaction on rsp. A scancode
// command updates shift/ctrl/alt (make and break codes) and toggles caps lock,
// ignores the 0xE0 prefix and other break codes, and maps any other make code
// to ASCII; caps lock swaps case for codes 0x10..0x32 only. A non-zero
// character is echoed (except newline and backspace) and pushed into a ring
// queue holding FIFO_DEPTH-1 characters; when full it is dropped and
// queue_dropped is set. A pop returns the oldest character, or 0 with
// read_valid low when empty. A clear empties the queue; opcode 3 is a no-op.
// Scancode, clear and no-op commands, and a pop of an empty queue, go straight
// to the response register; a pop of a stored character first passes the read
// state for the registered read of the character RAM. A new command is taken
// once the previous response has gone or is being taken in the same cycle.
module scancode_to_ascii_keyboard_fifo
    import kbfifo_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  kbfifo_in_t  cmd,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output kbfifo_out_t rsp
);

    localparam int unsigned AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] PTR_LAST = AW'(FIFO_DEPTH - 1);

    // idle: ready for a command; read: waiting on the RAM read data
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t      state_reg, state_next;
    logic [3:0]  mod_reg, mod_next;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic        rsp_valid_reg, rsp_valid_next;
    kbfifo_out_t rsp_reg, rsp_next;

    logic          cmd_fire;
    logic          empty;
    logic          full;
    logic [AW-1:0] wr_ptr_inc;
    logic [AW-1:0] rd_ptr_inc;
    logic          upper_sel;
    logic [7:0]    xlat_char;
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [7:0]    ram_rd_data;

    assign cmd_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;

    // Ring pointers wrap at FIFO_DEPTH, power of two or not
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_ptr_inc == rd_ptr_reg);

    // Case choice: shift, inverted by caps lock on the letter rows
    always_comb
    begin
        upper_sel = mod_reg[MOD_SHIFT];
        if (mod_reg[MOD_CAPS] && (cmd.scancode >= SC_CAPS_LO)
            && (cmd.scancode <= SC_CAPS_HI))
        begin
            upper_sel = !upper_sel;
        end
        xlat_char = upper_sel ? upper_map(cmd.scancode[6:0])
                              : lower_map(cmd.scancode[6:0]);
    end

    always_comb
    begin
        state_next     = state_reg;
        mod_next       = mod_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    rsp_next = '0;
                    case (cmd.opcode)
                        OP_SCAN:
                        begin
                            case (cmd.scancode)
                                SC_LSHIFT_MAKE, SC_RSHIFT_MAKE:
                                    mod_next[MOD_SHIFT] = 1'b1;
                                SC_LSHIFT_BREAK, SC_RSHIFT_BREAK:
                                    mod_next[MOD_SHIFT] = 1'b0;
                                SC_CTRL_MAKE:
                                    mod_next[MOD_CTRL] = 1'b1;
                                SC_CTRL_BREAK:
                                    mod_next[MOD_CTRL] = 1'b0;
                                SC_ALT_MAKE:
                                    mod_next[MOD_ALT] = 1'b1;
                                SC_ALT_BREAK:
                                    mod_next[MOD_ALT] = 1'b0;
                                SC_CAPS_MAKE:
                                    mod_next[MOD_CAPS] = !mod_reg[MOD_CAPS];
                                default:
                                begin
                                    // prefix and other break codes fall out here
                                    if (!cmd.scancode[7] && (xlat_char != 8'h00))
                                    begin
                                        if ((xlat_char != CH_NEWLINE)
                                            && (xlat_char != CH_BACKSPACE))
                                        begin
                                            rsp_next.echo_valid = 1'b1;
                                            rsp_next.echo_char  = xlat_char;
                                        end
                                        if (full)
                                        begin
                                            rsp_next.queue_dropped = 1'b1;
                                        end
                                        else
                                        begin
                                            ram_wr_en   = 1'b1;
                                            wr_ptr_next = wr_ptr_inc;
                                        end
                                    end
                                end
                            endcase
                        end
                        OP_POP:
                        begin
                            if (!empty)
                            begin
                                ram_rd_en   = 1'b1;
                                rd_ptr_next = rd_ptr_inc;
                                rsp_next.read_valid = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            wr_ptr_next = '0;
                            rd_ptr_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.available      = (wr_ptr_next != rd_ptr_next);
                    rsp_next.modifier_state = mod_next;
                    if (ram_rd_en)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        rsp_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                rsp_next.read_char = ram_rd_data;
                rsp_valid_next     = 1'b1;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mod_reg       <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_reg       <= mod_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // Character store; push and pop never hit the RAM in the same cycle
    kbfifo_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_char_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_ptr_reg),
        .wr_data (xlat_char),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd_data)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kbfifo_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int unsigned QDEPTH         = FIFO_DEPTH_DEF;
    localparam int unsigned RANDOM_ITEMS   = 200;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned SETTLE_CYCLES  = 10;

    // Opcode 3 has no name in the package; the block treats it as a no-op
    localparam logic [1:0] OP_NOP = 2'd3;

    // ------------------------------------------------------------------
    // Clock, reset and block I/O. Every input holds a known value from t=0.
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    kbfifo_in_t  cmd       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    kbfifo_out_t rsp;

    scancode_to_ascii_keyboard_fifo u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the keyboard state, advanced once per accepted command
    // ------------------------------------------------------------------
    logic [7:0]  keymap_lo [128];
    logic [7:0]  keymap_hi [128];
    logic [3:0]  shadow_mods;
    logic [7:0]  shadow_chars [QDEPTH];
    int unsigned shadow_wr;
    int unsigned shadow_rd;

    // Responses still owed by the block, oldest first
    kbfifo_out_t kb_results_due [$];

    // Bookkeeping for the checker and the closing summary
    int unsigned n_sent;
    int unsigned n_rsps;
    int unsigned n_mismatch;
    int unsigned n_queued;
    int unsigned n_dropped;
    int unsigned n_popped;
    int unsigned n_echoed;
    int unsigned stall_cycles;
    bit          no_gaps;

    // Builds both key maps. Printable keys come from the strings; the
    // '_' slots and the control characters are patched by index afterwards,
    // so a '_' that is a real key (shifted minus) survives untouched.
    function automatic void load_keymaps();
        string lo_keys;
        string hi_keys;
        lo_keys = "__1234567890-=__qwertyuiop[]__asdfghjkl;'`_\\zxcvbnm,./_*_ ";
        hi_keys = "__!@#$%^&*()_+__QWERTYUIOP{}__ASDFGHJKL:\"~_|ZXCVBNM<>?_*_ ";
        for (int i = 0; i < 128; i++)
        begin
            keymap_lo[i] = (i < lo_keys.len()) ? lo_keys[i] : 8'h00;
            keymap_hi[i] = (i < hi_keys.len()) ? hi_keys[i] : 8'h00;
        end
        foreach (keymap_lo[i])
        begin
            if (i == 0 || i == 29 || i == 42 || i == 54 || i == 56)
            begin
                keymap_lo[i] = 8'h00;
                keymap_hi[i] = 8'h00;
            end
        end
        keymap_lo[1]  = 8'h1B;  keymap_hi[1]  = 8'h1B;   // escape
        keymap_lo[14] = 8'h08;  keymap_hi[14] = 8'h08;   // backspace
        keymap_lo[15] = 8'h09;  keymap_hi[15] = 8'h09;   // tab
        keymap_lo[28] = 8'h0A;  keymap_hi[28] = 8'h0A;   // enter
        keymap_lo[74] = "-";    keymap_hi[74] = "-";     // keypad minus
        keymap_lo[78] = "+";    keymap_hi[78] = "+";     // keypad plus
    endfunction

    // Applies one command to the shadow state and returns the response the
    // block owes for it.
    function automatic kbfifo_out_t key_response(kbfifo_in_t c);
        kbfifo_out_t r;
        logic [7:0]  sc;
        logic [7:0]  ch;
        logic        upper_sel;
        int unsigned nxt;
        r  = '0;
        sc = c.scancode;
        case (c.opcode)
            OP_SCAN:
            begin
                if (sc == SC_LSHIFT_MAKE || sc == SC_RSHIFT_MAKE)
                    shadow_mods[MOD_SHIFT] = 1'b1;
                else if (sc == SC_LSHIFT_BREAK || sc == SC_RSHIFT_BREAK)
                    shadow_mods[MOD_SHIFT] = 1'b0;
                else if (sc == SC_CTRL_MAKE)
                    shadow_mods[MOD_CTRL] = 1'b1;
                else if (sc == SC_CTRL_BREAK)
                    shadow_mods[MOD_CTRL] = 1'b0;
                else if (sc == SC_ALT_MAKE)
                    shadow_mods[MOD_ALT] = 1'b1;
                else if (sc == SC_ALT_BREAK)
                    shadow_mods[MOD_ALT] = 1'b0;
                else if (sc == SC_CAPS_MAKE)
                    shadow_mods[MOD_CAPS] = ~shadow_mods[MOD_CAPS];
                else if (sc != SC_EXT_PREFIX && !sc[7])
                begin
                    // caps lock only swaps case on the letter block
                    upper_sel = shadow_mods[MOD_SHIFT];
                    if (sc >= SC_CAPS_LO && sc <= SC_CAPS_HI && shadow_mods[MOD_CAPS])
                        upper_sel = ~upper_sel;
                    ch = upper_sel ? keymap_hi[sc[6:0]] : keymap_lo[sc[6:0]];
                    if (ch != 8'h00)
                    begin
                        if (ch != CH_NEWLINE && ch != CH_BACKSPACE)
                        begin
                            r.echo_valid = 1'b1;
                            r.echo_char  = ch;
                        end
                        // ring keeps one slot spare to tell full from empty
                        nxt = (shadow_wr + 1) % QDEPTH;
                        if (nxt != shadow_rd)
                        begin
                            shadow_chars[shadow_wr] = ch;
                            shadow_wr = nxt;
                        end
                        else
                            r.queue_dropped = 1'b1;
                    end
                end
            end
            OP_POP:
            begin
                if (shadow_wr != shadow_rd)
                begin
                    r.read_char  = shadow_chars[shadow_rd];
                    r.read_valid = 1'b1;
                    shadow_rd    = (shadow_rd + 1) % QDEPTH;
                end
            end
            OP_CLEAR:
            begin
                shadow_wr = 0;
                shadow_rd = 0;
            end
            default: ;
        endcase
        r.available      = (shadow_wr != shadow_rd);
        r.modifier_state = shadow_mods;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            n_mismatch++;
            if (n_mismatch <= REPORT_LIMIT)
                $display("[%0t] response %0d, %s: expected %02h, got %02h",
                         $realtime, n_rsps, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Response checker. Responses are compared before this edge's command
    // is predicted, so the order of the queue is the order of transactions.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : rsp_checker
        kbfifo_out_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                n_rsps++;
                if (kb_results_due.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= REPORT_LIMIT)
                        $display("[%0t] response transaction with none outstanding: %h",
                                 $realtime, rsp);
                end
                else
                begin
                    want = kb_results_due.pop_front();
                    check_field("read_char",      want.read_char,      rsp.read_char);
                    check_field("read_valid",     want.read_valid,     rsp.read_valid);
                    check_field("available",      want.available,      rsp.available);
                    check_field("modifier_state", want.modifier_state, rsp.modifier_state);
                    check_field("echo_valid",     want.echo_valid,     rsp.echo_valid);
                    check_field("echo_char",      want.echo_char,      rsp.echo_char);
                    check_field("queue_dropped",  want.queue_dropped,  rsp.queue_dropped);
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                want = key_response(cmd);
                kb_results_due.push_back(want);
                n_queued  += (want.echo_valid || cmd.scancode == 8'h1C ||
                              cmd.scancode == 8'h0E) && cmd.opcode == OP_SCAN &&
                             !want.queue_dropped;
                n_dropped += want.queue_dropped;
                n_popped  += want.read_valid;
                n_echoed  += want.echo_valid;
            end
        end
    end

    // Watchdog: a run of cycles with no transaction on either side means
    // the block has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d responses owed",
                     stall_cycles, kb_results_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Response back-pressure: streaks of ready, long stalls, and stretches
    // of per-cycle random ready.
    // ------------------------------------------------------------------
    initial
    begin : rsp_ready_gen
        int unsigned sel;
        @(posedge rst_n);
        forever
        begin
            sel = $urandom_range(0, 9);
            if (sel < 3)
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
            else if (sel == 3)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(15, 50)) @(posedge clk);
            end
            else
            begin
                rsp_ready <= ($urandom_range(0, 3) != 0);
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Idle gap before a command: mostly back to back, a few long pauses
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Any make code that produces a character
    function automatic logic [7:0] pick_char_code();
        logic [7:0] code;
        do
            code = 8'($urandom_range(1, 78));
        while (keymap_lo[code[6:0]] == 8'h00);
        return code;
    endfunction

    // Issues one command transaction and returns at the edge it is taken.
    // Valid is only lowered when a gap follows, so it never drops and rises
    // within one time step.
    task automatic send_cmd(input logic [1:0] op, input logic [7:0] sc);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= {op, sc};
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        n_sent++;
    endtask

    // Holds off the sender until every owed response has arrived
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (kb_results_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Make and break of shift, ctrl and alt, the extended prefix and a plain break
    task automatic test_modifier_codes();
        send_cmd(OP_SCAN, SC_LSHIFT_MAKE);
        send_cmd(OP_SCAN, SC_CTRL_MAKE);
        send_cmd(OP_SCAN, SC_ALT_MAKE);
        send_cmd(OP_SCAN, SC_EXT_PREFIX);
        send_cmd(OP_SCAN, 8'hFF);
        send_cmd(OP_SCAN, SC_LSHIFT_BREAK);
        send_cmd(OP_SCAN, SC_RSHIFT_MAKE);
        send_cmd(OP_SCAN, SC_CTRL_BREAK);
        send_cmd(OP_SCAN, SC_ALT_BREAK);
        send_cmd(OP_SCAN, SC_RSHIFT_BREAK);
    endtask

    // Case selection, caps lock edges, non-echoed keys and every opcode
    task automatic test_keys_and_commands();
        send_cmd(OP_POP, 8'hFF);            // pop on an empty queue
        send_cmd(OP_SCAN, 8'h00);           // no character mapped
        send_cmd(OP_SCAN, 8'h7F);
        send_cmd(OP_SCAN, SC_CAPS_LO);      // 'q'
        send_cmd(OP_SCAN, SC_LSHIFT_MAKE);
        send_cmd(OP_SCAN, SC_CAPS_LO);      // 'Q'
        send_cmd(OP_SCAN, 8'h02);           // '!'
        send_cmd(OP_SCAN, SC_CAPS_MAKE);    // caps on while shifted
        send_cmd(OP_SCAN, SC_CAPS_HI);      // back to 'm'
        send_cmd(OP_SCAN, 8'h33);           // '<', outside the caps range
        send_cmd(OP_SCAN, SC_LSHIFT_BREAK);
        send_cmd(OP_SCAN, 8'h1E);           // 'A' from caps alone
        send_cmd(OP_SCAN, 8'h1C);           // enter: queued, not echoed
        send_cmd(OP_SCAN, 8'h0E);           // backspace: likewise
        send_cmd(OP_SCAN, SC_CAPS_MAKE);    // caps off
        send_cmd(OP_NOP, 8'h55);
        send_cmd(OP_POP, 8'h00);
        send_cmd(OP_CLEAR, 8'hAA);
        send_cmd(OP_POP, 8'h00);
    endtask

    // Fill past capacity so the last characters are dropped, then drain it
    // with more pops than there are entries.
    task automatic test_queue_full();
        send_cmd(OP_CLEAR, 8'($urandom_range(0, 255)));
        repeat (QDEPTH + 2)
            send_cmd(OP_SCAN, pick_char_code());
        wait_drained();
        repeat (QDEPTH + 1)
            send_cmd(OP_POP, 8'($urandom_range(0, 255)));
        wait_drained();
    endtask

    // One random step: mostly whole keystrokes, plus modifier traffic,
    // prefixed codes, stray bytes and the odd clear or no-op.
    task automatic random_event(input int unsigned pop_pct);
        int unsigned roll;
        logic [7:0]  code;
        roll = $urandom_range(0, 99);
        if (roll < pop_pct)
            send_cmd(OP_POP, 8'($urandom_range(0, 255)));
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send_cmd(OP_CLEAR, 8'($urandom_range(0, 255)));
            else if (roll < 4)
                send_cmd(OP_NOP, 8'($urandom_range(0, 255)));
            else if (roll < 60)
            begin
                code = pick_char_code();
                send_cmd(OP_SCAN, code);
                if ($urandom_range(0, 3) != 0)
                    send_cmd(OP_SCAN, code | 8'h80);
            end
            else if (roll < 72)
            begin
                case ($urandom_range(0, 3))
                    0:       send_cmd(OP_SCAN, SC_LSHIFT_MAKE);
                    1:       send_cmd(OP_SCAN, SC_RSHIFT_MAKE);
                    2:       send_cmd(OP_SCAN, SC_LSHIFT_BREAK);
                    default: send_cmd(OP_SCAN, SC_RSHIFT_BREAK);
                endcase
            end
            else if (roll < 78)
            begin
                case ($urandom_range(0, 3))
                    0:       send_cmd(OP_SCAN, SC_CTRL_MAKE);
                    1:       send_cmd(OP_SCAN, SC_CTRL_BREAK);
                    2:       send_cmd(OP_SCAN, SC_ALT_MAKE);
                    default: send_cmd(OP_SCAN, SC_ALT_BREAK);
                endcase
            end
            else if (roll < 82)
                send_cmd(OP_SCAN, SC_CAPS_MAKE);
            else if (roll < 88)
            begin
                send_cmd(OP_SCAN, SC_EXT_PREFIX);
                send_cmd(OP_SCAN, 8'($urandom_range(0, 255)));
            end
            else
                send_cmd(OP_SCAN, 8'($urandom_range(0, 255)));
        end
    endtask

    // Phases of typing-heavy, balanced and pop-heavy traffic, some with no
    // sender gaps, occasionally pausing until the block has caught up.
    task automatic test_random_traffic();
        int unsigned first;
        int unsigned pop_pct;
        first = n_sent;
        while (n_sent - first < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       pop_pct = 3;
                1:       pop_pct = 25;
                default: pop_pct = 55;
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(30, 120))
            begin
                if (n_sent - first < RANDOM_ITEMS)
                    random_event(pop_pct);
            end
            if ($urandom_range(0, 2) == 0)
                wait_drained();
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        shadow_mods = '0;
        shadow_wr   = 0;
        shadow_rd   = 0;
        load_keymaps();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_modifier_codes();
        test_keys_and_commands();
        test_queue_full();
        test_random_traffic();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d command transactions and %0d responses: %0d echoed,",
                 n_sent, n_rsps, n_echoed);
        $display("  %0d stored, %0d lost to a full queue, %0d popped; %0d mismatches.",
                 n_queued, n_dropped, n_popped, n_mismatch);
        if (n_mismatch == 0 && kb_results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            if (kb_results_due.size() != 0)
                $display("%0d responses never arrived", kb_results_due.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
